// File: hw/rtl/fvm_pkg.sv
// Shared constants and types for the feature vector match table.
`default_nettype none
package fvm_pkg;
    localparam int MAX_USERS = 16;
    localparam int MAX_DIM   = 128;
    localparam int USER_W    = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int UCNT_W    = $clog2(MAX_USERS + 1);
    localparam int DIM_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W     = $clog2(MAX_DIM + 2);
    localparam int ID_W      = 16;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 42;

    localparam logic [1:0] OP_ENROLL = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_REMOVED = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_MATCH   = 3'd4;
    localparam logic [2:0] ST_NOMATCH = 3'd5;
    localparam logic [2:0] ST_TOOLONG = 3'd6;

    localparam logic signed [ACC_W-1:0] SCORE_MINUS_ONE = -42'sd1073741824;
    localparam logic signed [ACC_W-1:0] THRESHOLD_RESET = 42'sd536870912;

    typedef struct packed {
        logic [ELEM_W-1:0] qdata;
        logic [DIM_W-1:0]  rd_addr;
        logic [DIM_W-1:0]  wr_addr;
        logic              clr;
        logic              mac_mul;
        logic              mac_acc;
        logic              wr_q;
        logic              wr_shift;
        logic              meta_load;
        logic              meta_shift;
        logic              cmp_en;
        logic [ID_W-1:0]   key;
        logic [CNT_W-1:0]  qlen;
    } ctl_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  len;
        logic [ELEM_W-1:0] rdata;
    } nbr_t;

    typedef struct packed {
        logic             found;
        logic [ID_W-1:0]  id;
        logic [ACC_W-1:0] score;
    } best_t;
endpackage
`default_nettype wire

// File: hw/rtl/fvm_cell.sv
// One table slot: id, length, vector memory, multiply-accumulate and compare stage.
`default_nettype none
module fvm_cell import fvm_pkg::*; (
    input  logic  aclk,
    input  ctl_t  ctl,
    input  logic  sel,
    input  logic  shen,
    input  logic  vld,
    input  nbr_t  nbr_in,
    output nbr_t  nbr_out,
    input  best_t best_in,
    output best_t best_out,
    output logic  hit
);
    logic [ELEM_W-1:0] mem [MAX_DIM];
    logic [ELEM_W-1:0] rdata_reg;
    logic [ID_W-1:0]   id_reg;
    logic [CNT_W-1:0]  len_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    best_t             best_reg;
    logic              better;

    always_ff @(posedge aclk) begin
        if (ctl.wr_q && sel) begin
            mem[ctl.wr_addr] <= ctl.qdata;
        end else if (ctl.wr_shift && shen) begin
            mem[ctl.wr_addr] <= nbr_in.rdata;
        end
        rdata_reg <= mem[ctl.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.meta_load && sel) begin
            id_reg  <= ctl.key;
            len_reg <= ctl.qlen;
        end else if (ctl.meta_shift && shen) begin
            id_reg  <= nbr_in.id;
            len_reg <= nbr_in.len;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mac_mul) begin
            prod_reg <= $signed(ctl.qdata) * $signed(rdata_reg);
        end
        if (ctl.clr) begin
            acc_reg <= '0;
        end else if (ctl.mac_acc) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign better = vld && (len_reg == ctl.qlen) && (acc_reg > $signed(best_in.score));

    always_ff @(posedge aclk) begin
        if (ctl.cmp_en) begin
            if (better) begin
                best_reg <= '{found: 1'b1, id: id_reg, score: acc_reg};
            end else begin
                best_reg <= best_in;
            end
        end
    end

    assign best_out = best_reg;
    assign nbr_out  = '{id: id_reg, len: len_reg, rdata: rdata_reg};
    assign hit      = vld && (id_reg == ctl.key);
endmodule
`default_nettype wire

// File: hw/rtl/feature_vector_match_table_top.sv
// Top level of the feature vector match table: sequencer, query buffer and row of slot cells.
// Each beat carries one vector element or a remove command. An element beat without last, an
// unknown opcode, and a rejected enroll or over-long vector are handled without leaving the
// idle state. Each slot is a cell with its own vector memory, and all cells sweep their
// memories in step at one element per cycle: a finished query of length L multiplies and
// accumulates over its L elements and then lets the best score ripple down the cell row to be
// judged, a finished enroll copies the buffer into its slot, and a remove sweeps all MAX_DIM
// elements while every later slot copies its neighbor's vector down by one. A new beat is taken
// only when the sequencer is idle and the result register is empty.
`default_nettype none
module feature_vector_match_table_top import fvm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // op[1:0], user_id[17:2], element[33:18], zeros
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // status[2:0], match_id[18:3], best_score[60:19], zeros
    input  wire logic        cfg_wr_en,
    input  wire logic [41:0] cfg_wr_data
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MAC   = 5'b00010,
        S_CMP   = 5'b00100,
        S_COPY  = 5'b01000,
        S_SHIFT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]        in_op;
    logic [ID_W-1:0]   in_id;
    logic [ELEM_W-1:0] in_elem;
    logic              accept;

    logic signed [ACC_W-1:0] thr_reg;
    logic [ELEM_W-1:0] qbuf [MAX_DIM];
    logic [ELEM_W-1:0] qdata_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic [UCNT_W-1:0] count_reg, count_next;
    logic [USER_W-1:0] tgt_reg, tgt_next;
    logic [ID_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]  qlen_reg, qlen_next;
    logic [CNT_W-1:0]  sweep_reg, sweep_next, sweep_end;
    logic [DIM_W-1:0]  addr_d_reg;
    logic              v1_reg, v2_reg, issue, clr;
    logic [UCNT_W-1:0] cmp_reg, cmp_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_status_reg, out_status_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [ACC_W-1:0]  out_score_reg, out_score_next;

    ctl_t              ctl;
    logic [MAX_USERS-1:0] hit, vld, sel, shen;
    nbr_t              nbr [MAX_USERS+1];
    best_t             best [MAX_USERS+1];
    logic              found_any;
    logic [USER_W-1:0] found_idx;
    best_t             final_best;

    assign in_op   = s_tdata[1:0];
    assign in_id   = s_tdata[17:2];
    assign in_elem = s_tdata[33:18];
    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (in_op == OP_ENROLL || in_op == OP_QUERY)
                && cnt_reg < CNT_W'(MAX_DIM)) begin
            qbuf[cnt_reg[DIM_W-1:0]] <= in_elem;
        end
        qdata_reg <= qbuf[sweep_reg[DIM_W-1:0]];
    end

    always_comb begin
        found_idx = '0;
        for (int i = MAX_USERS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found_idx = USER_W'(i);
            end
        end
    end
    assign found_any = |hit;

    assign cnt_inc = (cnt_reg < CNT_W'(MAX_DIM)) ? cnt_reg + 1'b1 : CNT_W'(MAX_DIM + 1);
    assign final_best = best[MAX_USERS];

    always_comb begin
        unique case (state_reg)
            S_MAC, S_COPY: sweep_end = qlen_reg;
            S_SHIFT:       sweep_end = CNT_W'(MAX_DIM);
            default:       sweep_end = '0;
        endcase
    end
    assign issue = sweep_reg < sweep_end;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        count_next      = count_reg;
        tgt_next        = tgt_reg;
        key_next        = key_reg;
        qlen_next       = qlen_reg;
        sweep_next      = issue ? sweep_reg + 1'b1 : sweep_reg;
        cmp_next        = cmp_reg;
        clr             = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_score_next  = out_score_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    key_next   = in_id;
                    sweep_next = '0;
                    out_id_next    = '0;
                    out_score_next = '0;
                    if (in_op == OP_REMOVE) begin
                        out_valid_next = !found_any;
                        out_status_next = ST_ABSENT;
                        tgt_next = found_idx;
                        if (found_any) begin
                            state_next = S_SHIFT;
                        end
                    end else if (in_op == OP_ENROLL || in_op == OP_QUERY) begin
                        cnt_next = cnt_inc;
                        if (s_tlast) begin
                            cnt_next  = '0;
                            qlen_next = cnt_inc;
                            if (cnt_inc > CNT_W'(MAX_DIM)) begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_TOOLONG;
                            end else if (in_op == OP_QUERY) begin
                                clr        = 1'b1;
                                state_next = S_MAC;
                            end else if (found_any) begin
                                tgt_next   = found_idx;
                                state_next = S_COPY;
                            end else if (count_reg == UCNT_W'(MAX_USERS)) begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_FULL;
                            end else begin
                                tgt_next   = count_reg[USER_W-1:0];
                                count_next = count_reg + 1'b1;
                                state_next = S_COPY;
                            end
                        end
                    end
                end
            end
            S_MAC: begin
                cmp_next = '0;
                if (!issue && !v1_reg && !v2_reg) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (cmp_reg == UCNT_W'(MAX_USERS)) begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_score_next = final_best.score;
                    if (final_best.found && $signed(final_best.score) >= thr_reg) begin
                        out_status_next = ST_MATCH;
                        out_id_next     = final_best.id;
                    end else begin
                        out_status_next = ST_NOMATCH;
                    end
                end else begin
                    cmp_next = cmp_reg + 1'b1;
                end
            end
            S_COPY: begin
                if (!issue && !v1_reg) begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_STORED;
                end
            end
            S_SHIFT: begin
                if (!issue && !v1_reg) begin
                    state_next      = S_IDLE;
                    count_next      = count_reg - 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_REMOVED;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            sweep_reg     <= '0;
            cmp_reg       <= '0;
            tgt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg && (state_reg == S_MAC);
            sweep_reg     <= sweep_next;
            cmp_reg       <= cmp_next;
            tgt_reg       <= tgt_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        qlen_reg       <= qlen_next;
        addr_d_reg     <= sweep_reg[DIM_W-1:0];
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_score_reg  <= out_score_next;
    end

    always_comb begin
        ctl            = '0;
        ctl.qdata      = qdata_reg;
        ctl.rd_addr    = sweep_reg[DIM_W-1:0];
        ctl.wr_addr    = addr_d_reg;
        ctl.clr        = clr;
        ctl.mac_mul    = v1_reg && (state_reg == S_MAC);
        ctl.mac_acc    = v2_reg;
        ctl.wr_q       = v1_reg && (state_reg == S_COPY);
        ctl.wr_shift   = v1_reg && (state_reg == S_SHIFT);
        ctl.meta_load  = (state_reg == S_COPY) && (sweep_reg == '0);
        ctl.meta_shift = (state_reg == S_SHIFT) && (sweep_reg == '0);
        ctl.cmp_en     = (state_reg == S_CMP) && (cmp_reg != UCNT_W'(MAX_USERS));
        ctl.key        = (state_reg == S_IDLE) ? in_id : key_reg;
        ctl.qlen       = qlen_reg;
    end

    assign nbr[MAX_USERS] = '0;
    assign best[0] = '{found: 1'b0, id: '0, score: SCORE_MINUS_ONE};

    for (genvar i = 0; i < MAX_USERS; i++) begin : g_cell
        assign vld[i]  = UCNT_W'(i) < count_reg;
        assign sel[i]  = tgt_reg == USER_W'(i);
        assign shen[i] = (USER_W'(i) >= tgt_reg) && (UCNT_W'(i + 1) < count_reg);
        fvm_cell u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .sel      (sel[i]),
            .shen     (shen[i]),
            .vld      (vld[i]),
            .nbr_in   (nbr[i+1]),
            .nbr_out  (nbr[i]),
            .best_in  (best[i]),
            .best_out (best[i+1]),
            .hit      (hit[i])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_score_reg, out_id_reg, out_status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= UCNT_W'(MAX_USERS))
        else $error("slot count exceeds table size");

    a_ids_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit))
        else $error("an id is held by more than one slot");

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("beat offered to a busy sequencer");
endmodule
`default_nettype wire

// File: dv/feature_vector_match_table_checker.sv
// Checker for the feature vector match table: predicts results from accepted beats and compares.
`timescale 1ns / 1ps
module feature_vector_match_table_checker import fvm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [41:0] cfg_wr_data,
    output int               fail_count,
    output int               pending_results
);
    typedef struct packed {
        logic [2:0]              status;
        logic [ID_W-1:0]         match_id;
        logic signed [ACC_W-1:0] best_score;
    } match_result_t;

    match_result_t result_queue[$];
    logic signed [ACC_W-1:0] threshold;
    logic [ID_W-1:0] slot_id[MAX_USERS];
    int slot_len[MAX_USERS];
    logic signed [ELEM_W-1:0] slot_vec[MAX_USERS][MAX_DIM];
    logic signed [ELEM_W-1:0] staged[MAX_DIM];
    int slot_count;
    int staged_len;

    assign pending_results = result_queue.size();

    function automatic int lookup_slot(logic [ID_W-1:0] id);
        for (int i = 0; i < slot_count; i++) begin
            if (slot_id[i] == id) return i;
        end
        return -1;
    endfunction

    task automatic push_result(logic [2:0] st, logic [ID_W-1:0] id,
                               logic signed [ACC_W-1:0] score);
        match_result_t r;
        r.status = st;
        r.match_id = id;
        r.best_score = score;
        result_queue.insert(result_queue.size(), r);
    endtask

    task automatic predict_beat(logic [1:0] op, logic [ID_W-1:0] id,
                                logic signed [ELEM_W-1:0] elem, logic last);
        int s;
        int len;
        logic signed [ACC_W-1:0] best;
        logic signed [ACC_W-1:0] dot;
        logic [ID_W-1:0] best_id;
        logic found;
        if (op == OP_REMOVE) begin
            s = lookup_slot(id);
            if (s < 0) begin
                push_result(ST_ABSENT, '0, '0);
            end else begin
                for (int i = s; i + 1 < slot_count; i++) begin
                    slot_id[i] = slot_id[i+1];
                    slot_len[i] = slot_len[i+1];
                    slot_vec[i] = slot_vec[i+1];
                end
                slot_count--;
                push_result(ST_REMOVED, '0, '0);
            end
            return;
        end
        if (op != OP_ENROLL && op != OP_QUERY) return;
        if (staged_len < MAX_DIM) begin
            staged[staged_len] = elem;
            staged_len++;
        end else begin
            staged_len = MAX_DIM + 1;
        end
        if (!last) return;
        len = staged_len;
        staged_len = 0;
        if (len > MAX_DIM) begin
            push_result(ST_TOOLONG, '0, '0);
            return;
        end
        if (op == OP_ENROLL) begin
            s = lookup_slot(id);
            if (s < 0) begin
                if (slot_count >= MAX_USERS) begin
                    push_result(ST_FULL, '0, '0);
                    return;
                end
                s = slot_count;
                slot_count++;
            end
            slot_id[s] = id;
            slot_len[s] = len;
            for (int i = 0; i < len; i++) slot_vec[s][i] = staged[i];
            push_result(ST_STORED, '0, '0);
            return;
        end
        best = SCORE_MINUS_ONE;
        best_id = '0;
        found = 1'b0;
        for (int k = 0; k < slot_count; k++) begin
            if (slot_len[k] != len) continue;
            dot = '0;
            for (int i = 0; i < len; i++) begin
                dot += ACC_W'(PROD_W'(staged[i]) * PROD_W'(slot_vec[k][i]));
            end
            if (dot > best) begin
                best = dot;
                best_id = slot_id[k];
                found = 1'b1;
            end
        end
        if (found && best >= threshold) push_result(ST_MATCH, best_id, best);
        else push_result(ST_NOMATCH, '0, best);
    endtask

    always @(posedge aclk) begin
        match_result_t got;
        match_result_t want;
        if (!aresetn) begin
            threshold <= THRESHOLD_RESET;
            slot_count = 0;
            staged_len = 0;
            fail_count <= 0;
            result_queue.delete();
        end else begin
            if (cfg_wr_en) threshold <= cfg_wr_data;
            if (s_tvalid && s_tready) begin
                predict_beat(s_tdata[1:0], s_tdata[17:2], s_tdata[33:18], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[2:0];
                got.match_id = m_tdata[18:3];
                got.best_score = m_tdata[60:19];
                if (result_queue.size() == 0) begin
                    if (fail_count < 10) $display("Unexpected result %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = result_queue.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) $display("Mismatch: expected %p, got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: dv/feature_vector_match_table_top_tb.sv
// Testbench top for the feature vector match table: stimulus, reset, clock and verdict.
`timescale 1ns / 1ps
module feature_vector_match_table_top_tb;
    import fvm_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [41:0] cfg_wr_data = '0;
    int          fail_count;
    int          pending_results;
    int          cycle_count = 0;
    int          rx_wait = 0;
    logic        stim_done = 1'b0;
    logic        hold_off = 1'b0;
    logic [ID_W-1:0] id_pool[8];

    always #2 aclk = ~aclk;

    feature_vector_match_table_top dut (.*);

    feature_vector_match_table_checker checker_i (.*);

    task automatic send_beat(logic [1:0] op, logic [15:0] id, logic [15:0] elem, logic last);
        int gap;
        gap = $urandom_range(0, 12);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, elem, id, op};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_vector(logic [1:0] op, logic [15:0] id, int len, int mode);
        logic [15:0] e;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: e = 16'($urandom());
                1: e = 16'h7fff;
                2: e = 16'h8000;
                default: e = 16'($urandom_range(0, 3) << 14);
            endcase
            send_beat(op, id, e, i == len - 1);
        end
    endtask

    task automatic write_threshold(logic [41:0] value);
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(posedge aclk);
        repeat (MAX_DIM + 2 * MAX_USERS + 10) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int items);
        int n;
        int len;
        int pick;
        n = 0;
        while (n < items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_DIM + 3)
                                              : $urandom_range(1, 4);
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2: send_vector(OP_ENROLL, id_pool[$urandom_range(0, 7)], len,
                                     $urandom_range(0, 3));
                3, 4, 5: send_vector(OP_QUERY, 16'($urandom()), len, $urandom_range(0, 3));
                6: send_beat(OP_REMOVE, id_pool[$urandom_range(0, 7)], 16'($urandom()),
                             1'($urandom()));
                7: send_beat(OP_REMOVE, 16'($urandom()), 16'($urandom()), 1'($urandom()));
                8: send_beat(OP_NOP, 16'($urandom()), 16'($urandom()), 1'($urandom()));
                default: send_vector(OP_ENROLL, 16'($urandom()), len, 0);
            endcase
            n += (pick >= 6 && pick <= 8) ? 1 : len;
        end
    endtask

    always @(negedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) rx_wait <= $urandom_range(0, 12);
    end

    initial begin
        @(posedge stim_done);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom());
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hffff;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        send_vector(OP_QUERY, 16'h0, 2, 0);
        send_beat(OP_REMOVE, 16'hffff, 16'h0, 1'b0);
        send_vector(OP_ENROLL, 16'h0000, 2, 1);
        send_vector(OP_ENROLL, 16'hffff, 2, 2);
        send_vector(OP_QUERY, 16'h0, 2, 1);
        send_vector(OP_QUERY, 16'h0, 2, 2);
        send_beat(OP_ENROLL, 16'h1234, 16'h4000, 1'b0);
        send_beat(OP_QUERY, 16'h1234, 16'h4000, 1'b1);
        send_beat(OP_NOP, 16'hffff, 16'hffff, 1'b1);
        send_vector(OP_QUERY, 16'h0, 3, 0);
        send_beat(OP_REMOVE, 16'h0000, 16'h0, 1'b1);
        send_vector(OP_ENROLL, 16'h5555, MAX_DIM + 1, 0);
        send_vector(OP_QUERY, 16'h0, MAX_DIM, 1);
        for (int i = 0; i < MAX_USERS + 1; i++) send_vector(OP_ENROLL, 16'(16'h100 + i), 1, 3);
        send_vector(OP_ENROLL, 16'h100, 1, 1);
        send_vector(OP_QUERY, 16'h0, 1, 1);
        write_threshold(42'h200_0000_0000);
        send_vector(OP_QUERY, 16'h0, 1, 2);
        write_threshold(42'h1ff_ffff_ffff);
        send_vector(OP_QUERY, 16'h0, 1, 1);
        write_threshold(42'h3ff_c000_0000);
        for (int i = 0; i < MAX_USERS; i++) begin
            send_beat(OP_REMOVE, 16'(16'h100 + i), 16'h0, 1'b0);
        end
        random_phase(400);
        write_threshold(42'h0);
        hold_off <= 1'b1;
        fork
            begin
                repeat (400) @(negedge aclk);
                hold_off <= 1'b0;
            end
            random_phase(100);
        join
        random_phase(400);
        write_threshold(42'h3ff_ffff_ffff);
        random_phase(300);
        write_threshold(42'h0_4000_0000);
        random_phase(300);
        s_tvalid <= 1'b0;
        stim_done <= 1'b1;
        while (pending_results != 0) @(posedge aclk);
        repeat (MAX_DIM + 2 * MAX_USERS + 20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
